[hw/rtl/flc_pkg.sv]
// Shared types and constants of the flame level classifier.
`timescale 1ns / 1ps
package flc_pkg;

	// Sample word and calibration store geometry
	localparam int SAMPLE_W    = 12;
	localparam int CAL_LOG2    = 4;
	localparam int CAL_SAMPLES = 1 << CAL_LOG2;
	localparam int IDX_W       = CAL_LOG2;
	localparam int KEEP_W      = CAL_LOG2 + 1;
	localparam int KEEP_MIN    = CAL_SAMPLES / 2;
	localparam int SUM_W       = SAMPLE_W + CAL_LOG2;
	localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

	// Tolerance is floor(rough * 3 / 10), done as a multiply by ceil(2^20 / 10)
	localparam int TOL_PROD_W = 31;
	localparam int TOL_SHIFT  = 20;
	localparam logic [16:0] TOL_RECIP = 17'd104858;

	// Reset values and fixed levels
	localparam logic [SAMPLE_W-1:0] HYST_RESET     = 12'd500;
	localparam logic [SAMPLE_W-1:0] MIN_VALID_RESET = 12'd500;
	localparam logic [SAMPLE_W-1:0] BASELINE_RESET = 12'd4000;
	localparam logic [SAMPLE_W-1:0] THRESH_RESET   = 12'd2000;
	localparam logic [SAMPLE_W-1:0] THRESH_UNCAL   = 12'd2000;
	localparam logic [SAMPLE_W-1:0] THRESH_FLOOR   = 12'd100;
	localparam logic [SAMPLE_W-1:0] STRONG_FLOOR   = 12'd400;

	// Grading ratios in percent
	localparam logic signed [20:0] PCT_SCALE  = 21'sd100;
	localparam logic signed [20:0] STRONG_PCT = 21'sd60;
	localparam logic signed [20:0] MEDIUM_PCT = 21'sd30;

	// Flame levels and intensities
	localparam logic [1:0] LVL_NONE   = 2'd0;
	localparam logic [1:0] LVL_WEAK   = 2'd1;
	localparam logic [1:0] LVL_MEDIUM = 2'd2;
	localparam logic [1:0] LVL_STRONG = 2'd3;
	localparam logic [6:0] INT_NONE   = 7'd0;
	localparam logic [6:0] INT_WEAK   = 7'd50;
	localparam logic [6:0] INT_MEDIUM = 7'd75;
	localparam logic [6:0] INT_STRONG = 7'd100;

	// Result kinds
	localparam logic KIND_DETECT = 1'b0;
	localparam logic KIND_CAL    = 1'b1;

	// Configuration register indexes
	localparam logic REG_HYST      = 1'b0;
	localparam logic REG_MIN_VALID = 1'b1;

	typedef enum logic [1:0] {
		ACT_DETECT = 2'd0,
		ACT_CAL    = 2'd1,
		ACT_SET    = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		CAL_OK      = 2'd0,
		CAL_OUTLIER = 2'd1,
		CAL_LOW     = 2'd2
	} cal_status_t;

	typedef enum logic [1:0] {
		FLC_IDLE,
		FLC_DET,
		FLC_CAL,
		FLC_CRES
	} flc_state_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SUM,
		CS_TOL,
		CS_DEV,
		CS_DIV
	} cal_state_t;

	// Outcome of one calibration run
	typedef struct packed {
		logic                done;
		cal_status_t         status;
		logic [SAMPLE_W-1:0] level;
		logic [SAMPLE_W-1:0] thresh;
	} cal_res_t;

endpackage

[hw/rtl/flc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module flc_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/flc_div.sv]
// Restoring divider, one quotient bit per cycle, for the kept-sample average.
`timescale 1ns / 1ps
module flc_div
	import flc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [KEEP_W-1:0] divisor,
	output logic              done,
	output logic [SUM_W-1:0]  quotient
);

	logic [KEEP_W-1:0]    rem_q;
	logic [SUM_W-1:0]     quo_q;
	logic [KEEP_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [KEEP_W:0]      trial;
	logic                 fits;

	// Shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && cnt_q == DIV_CNT_W'(1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? KEEP_W'(trial - {1'b0, dvs_q}) : KEEP_W'(trial);
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hw/rtl/flc_cal.sv]
// Calibration sequencer: two passes over the sample store, outlier reject, average.
`timescale 1ns / 1ps
module flc_cal
	import flc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SAMPLE_W-1:0] hyst,
	input  logic [SAMPLE_W-1:0] min_valid,
	output logic                rd_en,
	output logic [IDX_W-1:0]    rd_addr,
	input  logic [SAMPLE_W-1:0] rd_data,
	output cal_res_t            res
);

	cal_state_t           state_q, state_d;
	logic [IDX_W-1:0]     addr_q;
	logic                 iss_done_q;
	logic                 rvld_s1;
	logic [SUM_W-1:0]     acc_q;
	logic [KEEP_W-1:0]    kept_q;
	logic [SAMPLE_W-1:0]  rough_q;
	logic [SAMPLE_W-1:0]  tol_q;
	cal_res_t             res_q;

	logic                  pass_end;
	logic                  pass_clr;
	logic                  enough;
	logic                  div_start;
	logic                  div_done;
	logic [SUM_W-1:0]      div_quo;
	logic [SAMPLE_W-1:0]   dev;
	logic                  keep;
	logic [SAMPLE_W+1:0]   rough3;
	logic [TOL_PROD_W-1:0] tol_prod;
	logic [SAMPLE_W-1:0]   avg;
	logic [SAMPLE_W:0]     avg_less;
	logic [SAMPLE_W-1:0]   thr_pos;
	logic [SAMPLE_W-1:0]   thr;
	logic                  too_few;

	assign pass_end = iss_done_q && !rvld_s1;
	assign pass_clr = (state_q == CS_IDLE && start) || state_q == CS_TOL;
	assign enough   = kept_q >= KEEP_W'(KEEP_MIN);
	assign too_few  = state_q == CS_DEV && pass_end && !enough;

	// Deviation of the returning sample from the rough mean
	assign dev  = (rd_data > rough_q) ? rd_data - rough_q : rough_q - rd_data;
	assign keep = dev <= tol_q;

	// Tolerance: 30 percent of the rough mean, rounded down
	assign rough3   = {1'b0, rough_q, 1'b0} + {2'b00, rough_q};
	assign tol_prod = TOL_PROD_W'(rough3) * TOL_PROD_W'(TOL_RECIP);

	// Final average and clipped threshold
	assign avg      = div_quo[SAMPLE_W-1:0];
	assign avg_less = {1'b0, avg} - {1'b0, hyst};
	assign thr_pos  = (avg > hyst) ? avg_less[SAMPLE_W-1:0] : '0;
	assign thr      = (thr_pos < THRESH_FLOOR) ? THRESH_FLOOR : thr_pos;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (start) state_d = CS_SUM;
			end
			CS_SUM: begin
				if (pass_end) state_d = CS_TOL;
			end
			CS_TOL: begin
				state_d = CS_DEV;
			end
			CS_DEV: begin
				if (pass_end) state_d = enough ? CS_DIV : CS_IDLE;
			end
			CS_DIV: begin
				if (div_done) state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		rd_en     = 1'b0;
		div_start = 1'b0;
		case (state_q)
			CS_SUM: begin
				rd_en = !iss_done_q;
			end
			CS_DEV: begin
				rd_en     = !iss_done_q;
				div_start = pass_end && enough;
			end
			default: begin
				rd_en     = 1'b0;
				div_start = 1'b0;
			end
		endcase
	end

	// Walk the store, accumulate, and report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CS_IDLE;
			addr_q     <= '0;
			iss_done_q <= 1'b0;
			rvld_s1    <= 1'b0;
			acc_q      <= '0;
			kept_q     <= '0;
			res_q      <= '0;
		end else begin
			state_q    <= state_d;
			rvld_s1    <= rd_en;
			res_q.done <= too_few || div_done;
			if (pass_clr) begin
				addr_q     <= '0;
				iss_done_q <= 1'b0;
				acc_q      <= '0;
				kept_q     <= '0;
			end else begin
				if (rd_en) begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == IDX_W'(CAL_SAMPLES - 1)) iss_done_q <= 1'b1;
				end
				if (rvld_s1 && state_q == CS_SUM) begin
					acc_q <= acc_q + SUM_W'(rd_data);
				end
				if (rvld_s1 && state_q == CS_DEV && keep) begin
					acc_q  <= acc_q + SUM_W'(rd_data);
					kept_q <= kept_q + 1'b1;
				end
			end
			if (too_few) begin
				res_q.status <= CAL_OUTLIER;
			end
			if (div_done) begin
				res_q.level  <= avg;
				res_q.thresh <= thr;
				res_q.status <= (avg < min_valid) ? CAL_LOW : CAL_OK;
			end
		end
	end

	// Rough mean and tolerance between the passes
	always_ff @(posedge clk) begin
		if (state_q == CS_SUM && pass_end) begin
			rough_q <= acc_q[SUM_W-1:CAL_LOG2];
		end
		if (state_q == CS_TOL) begin
			tol_q <= SAMPLE_W'(tol_prod >> TOL_SHIFT);
		end
	end

	flc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (kept_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign rd_addr = addr_q;
	assign res     = res_q;

endmodule

[hw/rtl/flame_level_classifier_calibrated.sv]
// Top level of the flame level classifier with baseline calibration.
`timescale 1ns / 1ps
// A detect word is graded from its held sample against the baseline and threshold
// registers, and its result goes into the output register once that is free;
// set-threshold and non-final calibration words return nothing.
// The calibration word that fills the 16-entry sample store starts a sequencer that
// reads the store twice through its single read port and then runs a bit-serial
// divide before its result word. One word is worked at a time; the next is taken as
// soon as the current one has its result in the output register, even while that
// word still waits to be taken.
module flame_level_classifier_calibrated
	import flc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [SAMPLE_W-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [SAMPLE_W-1:0] sample_value,
	input  logic                comparator_hit,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                result_kind,
	output logic                flame_present,
	output logic [1:0]          flame_grade,
	output logic [6:0]          intensity_pct,
	output logic [1:0]          cal_status,
	output logic [SAMPLE_W-1:0] baseline_out,
	output logic [SAMPLE_W-1:0] threshold_out
);

	flc_state_t          state_q, state_d;
	logic [SAMPLE_W-1:0] hyst_q;
	logic [SAMPLE_W-1:0] minv_q;
	logic [SAMPLE_W-1:0] base_q;
	logic [SAMPLE_W-1:0] thr_q;
	logic                is_cal_q;
	logic [IDX_W-1:0]    fill_q;
	logic [SAMPLE_W-1:0] smp_q;
	logic                hit_q;
	cal_status_t         cstat_q;

	logic                out_valid_q;
	logic                kind_q;
	logic                present_q;
	logic [1:0]          level_q;
	logic [6:0]          pct_q;
	logic [1:0]          status_q;
	logic [SAMPLE_W-1:0] base_out_q;
	logic [SAMPLE_W-1:0] thr_out_q;

	action_t             act;
	logic                accept;
	logic                fill_last;
	logic                cal_start;
	logic                ram_we;
	logic                slot_free;
	logic                load_det;
	logic                load_cal;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic [SAMPLE_W-1:0] rd_data;
	cal_res_t            cal_res;

	logic [SAMPLE_W-1:0] eff_thr;
	logic signed [20:0]  drop;
	logic signed [20:0]  drop_pct;
	logic signed [20:0]  base_strong;
	logic signed [20:0]  base_medium;
	logic                det_present;
	logic [1:0]          det_level;
	logic [6:0]          det_pct;

	assign act       = action_t'(action);
	assign accept    = in_valid && in_ready;
	assign fill_last = fill_q == IDX_W'(CAL_SAMPLES - 1);
	assign ram_we    = accept && act == ACT_CAL;
	assign cal_start = ram_we && fill_last;
	assign slot_free = !out_valid_q || out_ready;

	// Grade the held detect sample
	assign eff_thr     = is_cal_q ? thr_q : THRESH_UNCAL;
	assign drop        = $signed({9'b0, base_q}) - $signed({9'b0, smp_q});
	assign drop_pct    = drop * PCT_SCALE;
	assign base_strong = $signed({9'b0, base_q}) * STRONG_PCT;
	assign base_medium = $signed({9'b0, base_q}) * MEDIUM_PCT;

	always_comb begin
		det_present = 1'b0;
		det_level   = LVL_NONE;
		det_pct     = INT_NONE;
		if (smp_q < eff_thr) begin
			det_present = 1'b1;
			if (drop_pct > base_strong || smp_q < STRONG_FLOOR) begin
				det_level = LVL_STRONG;
				det_pct   = INT_STRONG;
			end else if (drop_pct > base_medium) begin
				det_level = LVL_MEDIUM;
				det_pct   = INT_MEDIUM;
			end else begin
				det_level = LVL_WEAK;
				det_pct   = INT_WEAK;
			end
		end else if (hit_q) begin
			det_present = 1'b1;
			det_level   = LVL_WEAK;
			det_pct     = INT_WEAK;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FLC_IDLE: begin
				if (accept) begin
					case (act)
						ACT_DETECT: state_d = FLC_DET;
						ACT_CAL:    state_d = fill_last ? FLC_CAL : FLC_IDLE;
						default:    state_d = FLC_IDLE;
					endcase
				end
			end
			FLC_DET: begin
				if (slot_free) state_d = FLC_IDLE;
			end
			FLC_CAL: begin
				if (cal_res.done) state_d = FLC_CRES;
			end
			FLC_CRES: begin
				if (slot_free) state_d = FLC_IDLE;
			end
			default: state_d = FLC_IDLE;
		endcase
	end

	// Handshake and output-register loads
	always_comb begin
		in_ready = 1'b0;
		load_det = 1'b0;
		load_cal = 1'b0;
		case (state_q)
			FLC_IDLE: in_ready = 1'b1;
			FLC_DET:  load_det = slot_free;
			FLC_CRES: load_cal = slot_free;
			default: begin
				in_ready = 1'b0;
				load_det = 1'b0;
				load_cal = 1'b0;
			end
		endcase
	end

	// Control state, configuration and calibrated levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FLC_IDLE;
			hyst_q      <= HYST_RESET;
			minv_q      <= MIN_VALID_RESET;
			base_q      <= BASELINE_RESET;
			thr_q       <= THRESH_RESET;
			is_cal_q    <= 1'b0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == REG_HYST) hyst_q <= cfg_data;
			if (cfg_we && cfg_index == REG_MIN_VALID) minv_q <= cfg_data;
			if (accept && act == ACT_SET) thr_q <= sample_value;
			if (ram_we) fill_q <= fill_last ? '0 : fill_q + 1'b1;
			if (cal_res.done && cal_res.status == CAL_OK) begin
				base_q   <= cal_res.level;
				thr_q    <= cal_res.thresh;
				is_cal_q <= 1'b1;
			end
			if (load_det || load_cal) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the accepted word and load the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= sample_value;
			hit_q <= comparator_hit;
		end
		if (cal_res.done) begin
			cstat_q <= cal_res.status;
		end
		if (load_det) begin
			kind_q     <= KIND_DETECT;
			present_q  <= det_present;
			level_q    <= det_level;
			pct_q      <= det_pct;
			status_q   <= CAL_OK;
			base_out_q <= base_q;
			thr_out_q  <= eff_thr;
		end else if (load_cal) begin
			kind_q     <= KIND_CAL;
			present_q  <= 1'b0;
			level_q    <= LVL_NONE;
			pct_q      <= INT_NONE;
			status_q   <= cstat_q;
			base_out_q <= base_q;
			thr_out_q  <= eff_thr;
		end
	end

	flc_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (CAL_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q),
		.wdata (sample_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	flc_cal u_cal (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cal_start),
		.hyst      (hyst_q),
		.min_valid (minv_q),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res       (cal_res)
	);

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign flame_present = present_q;
	assign flame_grade   = level_q;
	assign intensity_pct = pct_q;
	assign cal_status    = status_q;
	assign baseline_out  = base_out_q;
	assign threshold_out = thr_out_q;

endmodule

[tb/sv/tb_flame_level_classifier_calibrated.sv]
// Testbench for the flame level classifier: directed table, random phases and a result scoreboard.
`timescale 1ns / 1ps
module tb_flame_level_classifier_calibrated;
	import flc_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int PHASES = 10;
	localparam int PHASE_WORDS = 155;
	localparam int CALM_PHASE = 4;
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_CYCLES = 100;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic                kind;
		logic                present;
		logic [1:0]          level;
		logic [6:0]          pct;
		logic [1:0]          status;
		logic [SAMPLE_W-1:0] base;
		logic [SAMPLE_W-1:0] thr;
	} flame_res_t;

	typedef struct {
		logic [1:0]          act;
		logic [SAMPLE_W-1:0] smp;
		logic                hit;
		bit                  typed;
		flame_res_t          res;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic                cfg_index = REG_HYST;
	logic [SAMPLE_W-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [1:0]          action = ACT_DETECT;
	logic [SAMPLE_W-1:0] sample_value = '0;
	logic                comparator_hit = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                result_kind;
	logic                flame_present;
	logic [1:0]          flame_grade;
	logic [6:0]          intensity_pct;
	logic [1:0]          cal_status;
	logic [SAMPLE_W-1:0] baseline_out;
	logic [SAMPLE_W-1:0] threshold_out;

	// Predictor state
	logic [SAMPLE_W-1:0] hyst_reg = HYST_RESET;
	logic [SAMPLE_W-1:0] minv_reg = MIN_VALID_RESET;
	logic [SAMPLE_W-1:0] cal_mem [CAL_SAMPLES];
	int                  cal_fill = 0;
	logic [SAMPLE_W-1:0] base_reg = BASELINE_RESET;
	logic [SAMPLE_W-1:0] thr_reg = THRESH_RESET;
	bit                  calibrated = 1'b0;

	flame_res_t pending_results[$];
	stim_row_t  dir_rows[$];
	int         fail_count = 0;
	int         stall_cycles = 0;
	bit         calm = 1'b0;
	flame_res_t seen_res;
	flame_res_t want_res;

	flame_level_classifier_calibrated dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.sample_value(sample_value),
		.comparator_hit(comparator_hit),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.flame_present(flame_present),
		.flame_grade(flame_grade),
		.intensity_pct(intensity_pct),
		.cal_status(cal_status),
		.baseline_out(baseline_out),
		.threshold_out(threshold_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [SAMPLE_W-1:0] clamp12(input int v);
		if (v < 0)
			return '0;
		if (v > 4095)
			return '1;
		return SAMPLE_W'(v);
	endfunction

	function automatic logic [SAMPLE_W-1:0] live_threshold();
		return calibrated ? thr_reg : THRESH_UNCAL;
	endfunction

	// Advance the classifier state by one word; return 1 when it yields a result
	function automatic bit classify_word(input logic [1:0] act, input logic [SAMPLE_W-1:0] smp,
			input logic hit, output flame_res_t res);
		logic [SAMPLE_W-1:0] eff;
		int drop;
		int base;
		int unsigned total;
		int unsigned rough;
		int unsigned tol;
		int unsigned kept;
		int unsigned kept_sum;
		int unsigned dev;
		int unsigned avg;
		int unsigned thr;
		bit has_res;
		res = '0;
		has_res = 1'b0;
		eff = live_threshold();
		case (act)
			ACT_DETECT: begin
				res.kind = KIND_DETECT;
				if (smp < eff) begin
					// grade by the drop below the baseline
					drop = int'(base_reg) - int'(smp);
					base = int'(base_reg);
					res.present = 1'b1;
					if (drop * 100 > 60 * base || smp < STRONG_FLOOR) begin
						res.level = LVL_STRONG;
						res.pct = INT_STRONG;
					end else if (drop * 100 > 30 * base) begin
						res.level = LVL_MEDIUM;
						res.pct = INT_MEDIUM;
					end else begin
						res.level = LVL_WEAK;
						res.pct = INT_WEAK;
					end
				end else if (hit) begin
					// comparator override
					res.present = 1'b1;
					res.level = LVL_WEAK;
					res.pct = INT_WEAK;
				end
				res.status = CAL_OK;
				res.base = base_reg;
				res.thr = eff;
				has_res = 1'b1;
			end
			ACT_CAL: begin
				cal_mem[cal_fill] = smp;
				cal_fill++;
				if (cal_fill == CAL_SAMPLES) begin
					cal_fill = 0;
					total = 0;
					for (int i = 0; i < CAL_SAMPLES; i++)
						total += cal_mem[i];
					rough = total / CAL_SAMPLES;
					tol = rough * 30 / 100;
					kept = 0;
					kept_sum = 0;
					// drop samples too far from the rough mean
					for (int i = 0; i < CAL_SAMPLES; i++) begin
						dev = (cal_mem[i] > rough) ? cal_mem[i] - rough : rough - cal_mem[i];
						if (dev <= tol) begin
							kept_sum += cal_mem[i];
							kept++;
						end
					end
					if (kept < KEEP_MIN) begin
						res.status = CAL_OUTLIER;
					end else begin
						avg = kept_sum / kept;
						if (avg < minv_reg) begin
							res.status = CAL_LOW;
						end else begin
							base_reg = SAMPLE_W'(avg);
							thr = (avg > hyst_reg) ? avg - hyst_reg : 0;
							if (thr < THRESH_FLOOR)
								thr = THRESH_FLOOR;
							thr_reg = SAMPLE_W'(thr);
							calibrated = 1'b1;
							res.status = CAL_OK;
						end
					end
					res.kind = KIND_CAL;
					res.base = base_reg;
					res.thr = live_threshold();
					has_res = 1'b1;
				end
			end
			ACT_SET: begin
				thr_reg = smp;
			end
			default: begin
			end
		endcase
		return has_res;
	endfunction

	task automatic add_checked(input logic [1:0] act, input int smp, input logic hit);
		stim_row_t row;
		row.act = act;
		row.smp = SAMPLE_W'(smp);
		row.hit = hit;
		row.typed = 1'b0;
		row.res = '0;
		dir_rows.push_back(row);
	endtask

	task automatic add_typed(input logic [1:0] act, input int smp, input logic hit,
			input logic kind, input logic pres, input logic [1:0] lvl, input logic [6:0] pct,
			input logic [1:0] st, input int base, input int thr);
		stim_row_t row;
		row.act = act;
		row.smp = SAMPLE_W'(smp);
		row.hit = hit;
		row.typed = 1'b1;
		row.res.kind = kind;
		row.res.present = pres;
		row.res.level = lvl;
		row.res.pct = pct;
		row.res.status = st;
		row.res.base = SAMPLE_W'(base);
		row.res.thr = SAMPLE_W'(thr);
		dir_rows.push_back(row);
	endtask

	// Drive one word at a falling edge and hold it until accepted
	task automatic push_word(input logic [1:0] act, input logic [SAMPLE_W-1:0] smp,
			input logic hit, input bit typed, input flame_res_t typed_res);
		flame_res_t res;
		bit has_res;
		while (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		sample_value <= smp;
		comparator_hit <= hit;
		do
			@(posedge clk);
		while (!in_ready);
		has_res = classify_word(act, smp, hit, res);
		if (has_res)
			pending_results.push_back(typed ? typed_res : res);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [SAMPLE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_HYST)
			hyst_reg = val;
		else
			minv_reg = val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_reg_value();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return '0;
		if (r < 50)
			return '1;
		if (r < 60)
			return HYST_RESET;
		return SAMPLE_W'($urandom_range(4095));
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_detect_sample();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return SAMPLE_W'($urandom_range(4095));
		// land near the threshold edge
		if (r < 70)
			return clamp12(int'(live_threshold()) - 300 + int'($urandom_range(400)));
		// land near the medium and strong grade edges
		return clamp12(int'(base_reg) * int'($urandom_range(80, 30)) / 100);
	endfunction

	// Receiver: stall at random outside the calm phase
	always @(negedge clk)
		out_ready <= calm || ($urandom_range(99) >= 14);

	// Compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_res.kind = result_kind;
			seen_res.present = flame_present;
			seen_res.level = flame_grade;
			seen_res.pct = intensity_pct;
			seen_res.status = cal_status;
			seen_res.base = baseline_out;
			seen_res.thr = threshold_out;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected result word: kind=%0d pres=%0d lvl=%0d pct=%0d st=%0d base=%0d thr=%0d",
						seen_res.kind, seen_res.present, seen_res.level, seen_res.pct,
						seen_res.status, seen_res.base, seen_res.thr);
			end else begin
				want_res = pending_results.pop_front();
				if (seen_res.kind !== want_res.kind || seen_res.present !== want_res.present ||
						seen_res.level !== want_res.level || seen_res.pct !== want_res.pct ||
						seen_res.status !== want_res.status || seen_res.base !== want_res.base ||
						seen_res.thr !== want_res.thr) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("mismatch at %0t: exp kind=%0d pres=%0d lvl=%0d pct=%0d st=%0d base=%0d thr=%0d",
							$realtime, want_res.kind, want_res.present, want_res.level,
							want_res.pct, want_res.status, want_res.base, want_res.thr);
						$display("                got kind=%0d pres=%0d lvl=%0d pct=%0d st=%0d base=%0d thr=%0d",
							seen_res.kind, seen_res.present, seen_res.level, seen_res.pct,
							seen_res.status, seen_res.base, seen_res.thr);
					end
				end
			end
		end
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int count;
		int r;
		int c;
		int j;
		int outp;
		logic [SAMPLE_W-1:0] hv;
		logic [SAMPLE_W-1:0] mv;
		stim_row_t row;

		// Directed table: reset state, field extremes, set threshold, one clean calibration
		add_typed(ACT_DETECT, 0, 1'b0, KIND_DETECT, 1'b1, LVL_STRONG, INT_STRONG, CAL_OK, 4000, 2000);
		add_typed(ACT_DETECT, 4095, 1'b0, KIND_DETECT, 1'b0, LVL_NONE, INT_NONE, CAL_OK, 4000, 2000);
		add_typed(ACT_DETECT, 4095, 1'b1, KIND_DETECT, 1'b1, LVL_WEAK, INT_WEAK, CAL_OK, 4000, 2000);
		add_typed(ACT_DETECT, 2000, 1'b0, KIND_DETECT, 1'b0, LVL_NONE, INT_NONE, CAL_OK, 4000, 2000);
		add_checked(ACT_DETECT, 1999, 1'b0);
		// a written threshold stays dormant until calibrated
		add_checked(ACT_SET, 3000, 1'b1);
		add_checked(ACT_DETECT, 2500, 1'b0);
		add_checked(ACT_UNUSED, 4095, 1'b1);
		for (int i = 0; i < CAL_SAMPLES - 1; i++)
			add_checked(ACT_CAL, 3000, i[0]);
		add_typed(ACT_CAL, 3000, 1'b1, KIND_CAL, 1'b0, LVL_NONE, INT_NONE, CAL_OK, 3000, 2500);
		add_checked(ACT_DETECT, 2400, 1'b0);
		add_checked(ACT_SET, 2600, 1'b0);
		add_checked(ACT_DETECT, 2550, 1'b0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			push_word(row.act, row.smp, row.hit, row.typed, row.res);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			// drain, let trailing words settle, then retune the registers
			in_valid <= 1'b0;
			while (pending_results.size() != 0)
				@(negedge clk);
			repeat (SETTLE_CYCLES) @(negedge clk);
			hv = (ph == 0) ? '1 : (ph == 1) ? '0 : pick_reg_value();
			mv = (ph == 0) ? '0 : (ph == 1) ? '1 : pick_reg_value();
			write_reg(REG_HYST, hv);
			write_reg(REG_MIN_VALID, mv);
			calm = (ph == CALM_PHASE);
			count = 0;
			while (count < PHASE_WORDS) begin
				r = $urandom_range(99);
				if (r < 30) begin
					// calibration session around a center, with a share of outliers
					r = $urandom_range(99);
					c = (r < 10) ? 0 : (r < 20) ? 4095 : int'($urandom_range(4095));
					r = $urandom_range(4);
					outp = (r < 2) ? 0 : (r == 2) ? 10 : (r == 3) ? 35 : 60;
					j = c / 8;
					for (int i = 0; i < CAL_SAMPLES; i++) begin
						if ($urandom_range(99) < 15) begin
							push_word(ACT_DETECT, pick_detect_sample(), 1'($urandom_range(1)),
								1'b0, '0);
							count++;
						end
						if ($urandom_range(99) < outp)
							push_word(ACT_CAL, SAMPLE_W'($urandom_range(4095)),
								1'($urandom_range(1)), 1'b0, '0);
						else
							push_word(ACT_CAL, clamp12(c - j + int'($urandom_range(2 * j))),
								1'($urandom_range(1)), 1'b0, '0);
						count++;
					end
				end else if (r < 40) begin
					if ($urandom_range(1))
						push_word(ACT_SET, SAMPLE_W'($urandom_range(4095)),
							1'($urandom_range(1)), 1'b0, '0);
					else
						push_word(ACT_SET, clamp12(int'(base_reg) - int'($urandom_range(600))),
							1'($urandom_range(1)), 1'b0, '0);
					count++;
				end else if (r < 43) begin
					// ignored word, not counted
					push_word(ACT_UNUSED, SAMPLE_W'($urandom_range(4095)),
						1'($urandom_range(1)), 1'b0, '0);
				end else begin
					push_word(ACT_DETECT, pick_detect_sample(), 1'($urandom_range(1)), 1'b0, '0);
					count++;
				end
			end
		end

		// Drain and close out
		in_valid <= 1'b0;
		calm = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		fail_count += pending_results.size();
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
